FILE: hdl/irmtx_pkg.sv
// Shared types and constants for the infrared UART packet transmitter.
`timescale 1ns / 1ps

package irmtx_pkg;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_LOAD  = 2'd1,
        OP_START = 2'd2
    } opcode_t;

    typedef enum logic [3:0] {
        PH_IDLE  = 4'd0,
        PH_START = 4'd1,
        PH_DATA0 = 4'd3,
        PH_DATA1 = 4'd4,
        PH_DATA2 = 4'd5,
        PH_DATA3 = 4'd6,
        PH_DATA4 = 4'd7,
        PH_DATA5 = 4'd8,
        PH_DATA6 = 4'd9,
        PH_DATA7 = 4'd10,
        PH_STOP  = 4'd11
    } phase_t;

    localparam int unsigned OPCODE_W      = 2;
    localparam int unsigned INDEX_W       = 6;
    localparam int unsigned BYTE_W        = 8;
    localparam int unsigned LENGTH_W      = 7;
    localparam int unsigned COMPARE_W     = 16;
    localparam logic [COMPARE_W-1:0] CARRIER_COMPARE_RESET = 16'd631;
    localparam logic [COMPARE_W-1:0] LINE_IDLE_COMPARE     = 16'd0;

endpackage

FILE: hdl/irmtx_store.sv
// Packet byte store with one write port and one registered read port.
`timescale 1ns / 1ps

module irmtx_store #(
    parameter int unsigned DEPTH  = 64,
    parameter int unsigned ADDR_W = 6
) (
    input  logic                         aclk,
    input  logic                         wr_en,
    input  logic [ADDR_W-1:0]            wr_addr,
    input  logic [irmtx_pkg::BYTE_W-1:0] wr_data,
    input  logic                         rd_en,
    input  logic [ADDR_W-1:0]            rd_addr,
    output logic [irmtx_pkg::BYTE_W-1:0] rd_data
);
    import irmtx_pkg::*;

    logic [BYTE_W-1:0] mem [DEPTH];
    logic [BYTE_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hdl/ir_modulated_uart_packet_tx.sv
// Top level of the infrared-modulated 8N1 UART packet transmitter.
`timescale 1ns / 1ps

// Each transaction carries one command: a bit tick, a byte load into the packet store, or a
// packet start with a length. Every command yields exactly one result transaction with the
// PWM compare value now driven, the busy flag, a reject flag and a done flag. The block takes
// one command per cycle while results are taken: a command sits in an input register, is
// executed into the result register, and a second command can wait in the input register
// while a result is not yet taken. Loads and starts are refused while a packet is being sent.
// The carrier compare value is written through cfg_wr_en and cfg_wr_data and should only
// change while the block is idle.
module ir_modulated_uart_packet_tx #(
    parameter int unsigned BUFFER_DEPTH = 64
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [irmtx_pkg::COMPARE_W-1:0] cfg_wr_data,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [irmtx_pkg::OPCODE_W-1:0]  s_opcode,
    input  logic [irmtx_pkg::INDEX_W-1:0]   s_byte_index,
    input  logic [irmtx_pkg::BYTE_W-1:0]    s_byte_value,
    input  logic [irmtx_pkg::LENGTH_W-1:0]  s_packet_length,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [irmtx_pkg::COMPARE_W-1:0] m_drive_compare,
    output logic                            m_busy_res,
    output logic                            m_rejected,
    output logic                            m_packet_done
);
    import irmtx_pkg::*;

    localparam int unsigned ADDR_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam int unsigned DEPTH_CW = $clog2(BUFFER_DEPTH + 1);
    localparam int unsigned CMP_W = (DEPTH_CW > LENGTH_W) ? DEPTH_CW : LENGTH_W;
    localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(BUFFER_DEPTH);

    logic                 in_valid_reg;
    logic [OPCODE_W-1:0]  in_opcode_reg;
    logic [INDEX_W-1:0]   in_index_reg;
    logic [BYTE_W-1:0]    in_value_reg;
    logic [LENGTH_W-1:0]  in_length_reg;

    logic                 out_valid_reg;
    logic [COMPARE_W-1:0] out_drive_reg;
    logic                 out_busy_reg;
    logic                 out_rejected_reg;
    logic                 out_done_reg;

    phase_t               bit_phase_reg, bit_phase_next;
    logic [CMP_W-1:0]     send_pointer_reg, send_pointer_next;
    logic [CMP_W-1:0]     send_length_reg, send_length_next;
    logic [COMPARE_W-1:0] drive_level_reg, drive_level_next;
    logic [COMPARE_W-1:0] carrier_compare_reg;

    logic                 advance;
    logic                 busy;
    logic                 length_ok;
    logic                 index_ok;
    logic [3:0]           data_offset;
    logic [BYTE_W-1:0]    shift_byte;
    logic                 fetch;
    logic [ADDR_W-1:0]    fetch_addr;
    logic                 store_we;
    logic [ADDR_W-1:0]    store_addr;
    logic [CMP_W-1:0]     index_ext;
    logic                 rejected;
    logic                 done;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_opcode_reg <= s_opcode;
            in_index_reg  <= s_byte_index;
            in_value_reg  <= s_byte_value;
            in_length_reg <= s_packet_length;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            carrier_compare_reg <= CARRIER_COMPARE_RESET;
        end else if (cfg_wr_en) begin
            carrier_compare_reg <= cfg_wr_data;
        end
    end

    assign busy        = (bit_phase_reg != PH_IDLE);
    assign index_ext   = CMP_W'(in_index_reg);
    assign length_ok   = (in_length_reg != '0) && (CMP_W'(in_length_reg) <= DEPTH_C);
    assign index_ok    = (index_ext < DEPTH_C);
    assign data_offset = bit_phase_reg - 4'(PH_DATA0);
    assign store_addr  = index_ext[ADDR_W-1:0];

    // Next state of the bit sequencer.
    always_comb begin
        bit_phase_next    = bit_phase_reg;
        send_pointer_next = send_pointer_reg;
        send_length_next  = send_length_reg;
        drive_level_next  = drive_level_reg;
        fetch             = 1'b0;
        fetch_addr        = send_pointer_reg[ADDR_W-1:0];
        case (opcode_t'(in_opcode_reg))
            OP_START: begin
                if (!busy && length_ok) begin
                    drive_level_next  = LINE_IDLE_COMPARE;
                    send_length_next  = CMP_W'(in_length_reg);
                    send_pointer_next = CMP_W'(1);
                    fetch             = 1'b1;
                    fetch_addr        = '0;
                    bit_phase_next    = PH_START;
                end
            end
            OP_TICK: begin
                case (bit_phase_reg)
                    PH_IDLE: begin
                        bit_phase_next = PH_IDLE;
                    end
                    PH_START: begin
                        drive_level_next = carrier_compare_reg;
                        bit_phase_next   = PH_DATA0;
                    end
                    PH_DATA0, PH_DATA1, PH_DATA2, PH_DATA3,
                    PH_DATA4, PH_DATA5, PH_DATA6, PH_DATA7: begin
                        drive_level_next = shift_byte[data_offset[2:0]] ?
                                           LINE_IDLE_COMPARE : carrier_compare_reg;
                        bit_phase_next   = phase_t'(bit_phase_reg + 4'd1);
                    end
                    PH_STOP: begin
                        drive_level_next = LINE_IDLE_COMPARE;
                        if (send_pointer_reg >= send_length_reg) begin
                            bit_phase_next = PH_IDLE;
                        end else begin
                            fetch             = 1'b1;
                            send_pointer_next = send_pointer_reg + CMP_W'(1);
                            bit_phase_next    = PH_START;
                        end
                    end
                    default: begin
                        bit_phase_next = PH_IDLE;
                    end
                endcase
            end
            default: begin
                bit_phase_next = bit_phase_reg;
            end
        endcase
    end

    // Per-transaction flags and store write.
    always_comb begin
        rejected = 1'b0;
        done     = 1'b0;
        store_we = 1'b0;
        case (opcode_t'(in_opcode_reg))
            OP_LOAD: begin
                if (busy || !index_ok) begin
                    rejected = 1'b1;
                end else begin
                    store_we = advance;
                end
            end
            OP_START: begin
                rejected = busy || !length_ok;
            end
            OP_TICK: begin
                done = (bit_phase_reg == PH_STOP) && (send_pointer_reg >= send_length_reg);
            end
            default: begin
                rejected = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bit_phase_reg    <= PH_IDLE;
            send_pointer_reg <= '0;
            send_length_reg  <= '0;
            drive_level_reg  <= LINE_IDLE_COMPARE;
        end else if (advance) begin
            bit_phase_reg    <= bit_phase_next;
            send_pointer_reg <= send_pointer_next;
            send_length_reg  <= send_length_next;
            drive_level_reg  <= drive_level_next;
        end
    end

    irmtx_store #(
        .DEPTH  (BUFFER_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (store_we),
        .wr_addr (store_addr),
        .wr_data (in_value_reg),
        .rd_en   (advance && fetch),
        .rd_addr (fetch_addr),
        .rd_data (shift_byte)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_drive_reg    <= drive_level_next;
            out_busy_reg     <= (bit_phase_next != PH_IDLE);
            out_rejected_reg <= rejected;
            out_done_reg     <= done;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_drive_compare = out_drive_reg;
    assign m_busy_res      = out_busy_reg;
    assign m_rejected      = out_rejected_reg;
    assign m_packet_done   = out_done_reg;

`ifndef NO_ASSERTIONS
    a_done_means_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_done_reg) |-> !out_busy_reg)
        else $error("Packet done reported while still busy.");

    a_done_not_rejected: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> !(out_done_reg && out_rejected_reg))
        else $error("A transaction was both rejected and done.");

    a_pointer_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        busy |-> (send_length_reg != '0) && (send_pointer_reg <= send_length_reg)
                 && (send_length_reg <= DEPTH_C))
        else $error("Send pointer or length out of range while busy.");

    a_fetch_starts_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && fetch) |=> (bit_phase_reg == PH_START))
        else $error("Byte fetch not followed by a pending start bit.");

    a_no_load_while_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        store_we |-> !busy)
        else $error("Store written while a packet is being sent.");
`endif

endmodule
